/* hdl/tms_pkg.sv */
// Shared types, codes, constants and helper functions of the touch move smoothing block.
`default_nettype none

package tms_pkg;

    localparam int POS_W   = 24;
    localparam int REM_W   = 26;
    localparam int NOW_W   = 32;
    localparam int STEP_W  = 6;
    localparam int THR_W   = 16;
    localparam int TOUT_W  = 16;
    localparam int ROM_N   = 64;

    // round(exp(-0.04) * 2^32)
    localparam logic [63:0] EDECAY = 64'd4126559220;

    localparam logic [THR_W-1:0]  SNAP_THR_RST    = 16'd16;
    localparam logic [TOUT_W-1:0] TIMEOUT_MS_RST  = 16'd300;
    localparam logic [STEP_W-1:0] MAX_STEP_MS_RST = 6'd33;

    localparam logic [1:0] CFG_SNAP_THR    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_MS  = 2'd1;
    localparam logic [1:0] CFG_MAX_STEP_MS = 2'd2;

    localparam logic [1:0] FUNC_RAW   = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_BREAK = 2'd2;

    localparam logic [2:0] KIND_DOWN   = 3'd0;
    localparam logic [2:0] KIND_MOVE   = 3'd1;
    localparam logic [2:0] KIND_UP     = 3'd2;
    localparam logic [2:0] KIND_CANCEL = 3'd3;

    localparam logic EVK_MOVE = 1'b0;
    localparam logic EVK_UP   = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_READY   = 2'd1,
        MODE_ONGOING = 2'd2,
        MODE_END     = 2'd3
    } mode_t;

    typedef struct packed {
        logic [THR_W-1:0]  snap_thr;
        logic [TOUT_W-1:0] timeout_ms;
        logic [STEP_W-1:0] max_step_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]              func;
        logic [2:0]              touch_kind;
        logic signed [POS_W-1:0] pos_y;
        logic [NOW_W-1:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic                    intercept;
        logic                    event_valid;
        logic                    event_kind;
        logic signed [POS_W-1:0] event_y;
        mode_t                   mode_after;
    } result_t;

    // One entry of the smoothing factor table, 1 - exp(-0.04 * k), abits fraction bits.
    // Only ever evaluated on constants.
    function automatic logic [31:0] alpha_entry(input int k, input int abits);
        logic [63:0] d;
        logic [63:0] a;
        int          i;
        d = 64'h1_0000_0000;
        for (i = 1; i <= k; i++)
        begin
            d = (d * EDECAY + 64'h8000_0000) >> 32;
        end
        a = ((64'd1 << 32) - d + (64'd1 << (31 - abits))) >> (32 - abits);
        return a[31:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [REM_W:0] x);
        if (x > 27'sd8388607)
            return 24'sh7FFFFF;
        else if (x < -27'sd8388608)
            return 24'sh800000;
        else
            return x[POS_W-1:0];
    endfunction

    function automatic logic signed [REM_W-1:0] sat_rem(input logic signed [REM_W:0] x);
        if (x > 27'sd33554431)
            return 26'sh1FFFFFF;
        else if (x < -27'sd33554432)
            return 26'sh2000000;
        else
            return x[REM_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/tms_engine.sv */
// Touch state, mode machine and smoothing step; one item per enabled cycle.
`default_nettype none

module tms_engine
    import tms_pkg::*;
#(
    parameter int TIME_BITS  = 32,
    parameter int ALPHA_BITS = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    step_en,
    input  wire item_t   item,
    output result_t      result
);

    localparam int PROD_W = REM_W + ALPHA_BITS;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (ALPHA_BITS - 1);

    // smoothing factor table
    logic [ALPHA_BITS-1:0] alpha_rom [ROM_N];
    for (genvar k = 0; k < ROM_N; k++)
    begin : g_rom
        localparam logic [ALPHA_BITS-1:0] AVAL = ALPHA_BITS'(alpha_entry(k, ALPHA_BITS));
        assign alpha_rom[k] = AVAL;
    end

    mode_t                   mode_reg, mode_next;
    logic                    down_valid_reg, down_valid_next;
    logic signed [POS_W-1:0] down_y_reg, down_y_next;
    logic [TIME_BITS-1:0]    down_time_reg, down_time_next;
    logic                    move_valid_reg, move_valid_next;
    logic signed [POS_W-1:0] move_y_reg, move_y_next;
    logic [TIME_BITS-1:0]    move_time_reg, move_time_next;
    logic                    up_valid_reg, up_valid_next;
    logic                    gen_valid_reg, gen_valid_next;
    logic signed [POS_W-1:0] gen_y_reg, gen_y_next;
    logic [TIME_BITS-1:0]    gen_time_reg, gen_time_next;
    logic signed [REM_W-1:0] rem_reg, rem_next;

    logic [TIME_BITS-1:0]    now_v;
    logic signed [POS_W-1:0] ref_y;
    logic signed [REM_W:0]   rem_sum;

    logic                    gen_ok;
    logic signed [POS_W-1:0] base_y;
    logic [TIME_BITS-1:0]    base_time;
    logic [TIME_BITS-1:0]    gdiff;
    logic [TIME_BITS-1:0]    gdt_full;
    logic [STEP_W-1:0]       dt;
    logic [REM_W-1:0]        mag;
    logic                    in_band;
    logic [ALPHA_BITS-1:0]   alpha_v;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W:0]         prod_rnd;
    logic [REM_W-1:0]        smag;
    logic signed [REM_W:0]   smag_s;
    logic signed [REM_W:0]   step_v;
    logic signed [POS_W-1:0] gy_new;
    logic signed [REM_W-1:0] rem_new;
    logic                    end_after;

    logic [TIME_BITS-1:0]    tref;
    logic [TIME_BITS-1:0]    tdiff;
    logic [TIME_BITS-1:0]    tdt;
    logic                    timed_out;
    logic                    up_ok;
    logic signed [POS_W-1:0] up_y;

    logic                    to_idle, to_ready, to_ongoing;

    assign now_v   = TIME_BITS'(item.now_ms);
    assign ref_y   = move_valid_reg ? move_y_reg : down_y_reg;
    assign rem_sum = (REM_W + 1)'(rem_reg) + (REM_W + 1)'(item.pos_y) - (REM_W + 1)'(ref_y);

    // smoothing step; the first step starts from the down position at the move time
    assign gen_ok    = gen_valid_reg || (move_valid_reg && down_valid_reg);
    assign base_y    = gen_valid_reg ? gen_y_reg : down_y_reg;
    assign base_time = gen_valid_reg ? gen_time_reg : move_time_reg;
    assign gdiff     = now_v - base_time;
    assign gdt_full  = gdiff[TIME_BITS-1] ? '0 : gdiff;
    assign dt        = (gdt_full > TIME_BITS'(cfg.max_step_ms)) ? cfg.max_step_ms
                                                                : gdt_full[STEP_W-1:0];
    assign mag       = rem_reg[REM_W-1] ? (~rem_reg + 1'b1) : rem_reg;
    assign in_band   = mag <= REM_W'(cfg.snap_thr);
    assign alpha_v   = alpha_rom[dt];
    assign prod      = PROD_W'(mag) * PROD_W'(alpha_v);
    assign prod_rnd  = {1'b0, prod} + ROUND_HALF;
    assign smag      = prod_rnd[ALPHA_BITS +: REM_W];
    assign smag_s    = signed'({1'b0, smag});
    assign step_v    = in_band ? (REM_W + 1)'(rem_reg)
                               : (rem_reg[REM_W-1] ? -smag_s : smag_s);
    assign gy_new    = sat_pos((REM_W + 1)'(base_y) + step_v);
    assign rem_new   = sat_rem((REM_W + 1)'(rem_reg) - step_v);
    // whole remainder taken leaves zero; otherwise |rem| shrinks by exactly smag
    assign end_after = gen_ok ? (in_band || ((mag - smag) <= REM_W'(cfg.snap_thr)))
                              : in_band;

    // a backwards clock counts as zero elapsed time
    assign tref      = move_valid_reg ? move_time_reg : down_time_reg;
    assign tdiff     = now_v - tref;
    assign tdt       = tdiff[TIME_BITS-1] ? '0 : tdiff;
    assign timed_out = down_valid_reg && (tdt >= TIME_BITS'(cfg.timeout_ms));
    assign up_ok     = gen_valid_reg || down_valid_reg;
    assign up_y      = gen_valid_reg ? gen_y_reg : down_y_reg;

    always_comb
    begin
        mode_next       = mode_reg;
        down_valid_next = down_valid_reg;
        down_y_next     = down_y_reg;
        down_time_next  = down_time_reg;
        move_valid_next = move_valid_reg;
        move_y_next     = move_y_reg;
        move_time_next  = move_time_reg;
        up_valid_next   = up_valid_reg;
        gen_valid_next  = gen_valid_reg;
        gen_y_next      = gen_y_reg;
        gen_time_next   = gen_time_reg;
        rem_next        = rem_reg;
        to_idle         = 1'b0;
        to_ready        = 1'b0;
        to_ongoing      = 1'b0;
        result          = '0;

        case (item.func)
            FUNC_RAW:
            begin
                case (item.touch_kind)
                    KIND_DOWN:
                    begin
                        down_valid_next = 1'b1;
                        down_y_next     = item.pos_y;
                        down_time_next  = now_v;
                    end
                    KIND_MOVE:
                    begin
                        if (down_valid_reg)
                            rem_next = sat_rem(rem_sum);
                        move_valid_next = 1'b1;
                        move_y_next     = item.pos_y;
                        move_time_next  = now_v;
                    end
                    KIND_UP:
                    begin
                        up_valid_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                result.intercept = 1'b1;
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (item.touch_kind == KIND_DOWN)
                        begin
                            to_ready         = 1'b1;
                            result.intercept = 1'b0;
                        end
                        else
                            to_idle = 1'b1;
                    end
                    MODE_READY:
                    begin
                        if (item.touch_kind == KIND_MOVE)
                            to_ongoing = 1'b1;
                        else
                        begin
                            to_idle = 1'b1;
                            if (item.touch_kind == KIND_CANCEL)
                                result.intercept = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (item.touch_kind == KIND_DOWN)
                            to_ready = 1'b1;
                        else if (item.touch_kind == KIND_MOVE)
                            to_ongoing = 1'b1;
                        else if (item.touch_kind == KIND_CANCEL)
                        begin
                            to_idle          = 1'b1;
                            result.intercept = 1'b0;
                        end
                    end
                endcase
            end
            FUNC_TICK:
            begin
                if (mode_reg == MODE_ONGOING)
                begin
                    if (gen_ok)
                    begin
                        gen_valid_next     = 1'b1;
                        gen_y_next         = gy_new;
                        gen_time_next      = now_v;
                        rem_next           = rem_new;
                        result.event_valid = 1'b1;
                        result.event_y     = gy_new;
                    end
                    if (end_after)
                        mode_next = MODE_END;
                end
                else if (mode_reg == MODE_END)
                begin
                    if (up_valid_reg || timed_out)
                    begin
                        if (up_ok)
                        begin
                            result.event_valid = 1'b1;
                            result.event_kind  = EVK_UP;
                            result.event_y     = up_y;
                        end
                        to_idle = 1'b1;
                    end
                    else if (gen_ok)
                    begin
                        gen_valid_next     = 1'b1;
                        gen_y_next         = gy_new;
                        gen_time_next      = now_v;
                        rem_next           = rem_new;
                        result.event_valid = 1'b1;
                        result.event_y     = gy_new;
                    end
                end
            end
            FUNC_BREAK:
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    if (up_ok)
                    begin
                        result.event_valid = 1'b1;
                        result.event_kind  = EVK_UP;
                        result.event_y     = up_y;
                    end
                    to_idle = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (to_idle)
        begin
            mode_next       = MODE_IDLE;
            down_valid_next = 1'b0;
            down_y_next     = '0;
            down_time_next  = '0;
            move_valid_next = 1'b0;
            move_y_next     = '0;
            move_time_next  = '0;
            up_valid_next   = 1'b0;
            gen_valid_next  = 1'b0;
            gen_y_next      = '0;
            gen_time_next   = '0;
            rem_next        = '0;
        end
        else if (to_ready)
        begin
            mode_next       = MODE_READY;
            up_valid_next   = 1'b0;
            move_valid_next = 1'b0;
        end
        else if (to_ongoing)
        begin
            mode_next = MODE_ONGOING;
        end

        result.mode_after = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            down_valid_reg <= 1'b0;
            down_y_reg     <= '0;
            down_time_reg  <= '0;
            move_valid_reg <= 1'b0;
            move_y_reg     <= '0;
            move_time_reg  <= '0;
            up_valid_reg   <= 1'b0;
            gen_valid_reg  <= 1'b0;
            gen_y_reg      <= '0;
            gen_time_reg   <= '0;
            rem_reg        <= '0;
        end
        else if (step_en)
        begin
            mode_reg       <= mode_next;
            down_valid_reg <= down_valid_next;
            down_y_reg     <= down_y_next;
            down_time_reg  <= down_time_next;
            move_valid_reg <= move_valid_next;
            move_y_reg     <= move_y_next;
            move_time_reg  <= move_time_next;
            up_valid_reg   <= up_valid_next;
            gen_valid_reg  <= gen_valid_next;
            gen_y_reg      <= gen_y_next;
            gen_time_reg   <= gen_time_next;
            rem_reg        <= rem_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/touch_move_smoothing_fsm.sv */
// Top level: stream ports, configuration registers, input and result registers.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: pos_y, now_ms; tuser: func, touch_kind
//  m_*     | out | m_tvalid/m_tready  | tdata: event_y, mode_after; tuser: flags
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle sustained while the result is taken; an accepted item passes the input
// register, then the step logic with its single multiply into the result register, and
// m_tvalid rises once the result register is loaded.
// A stalled result holds while the input register still takes one more item.
// Reset clears the touch state to idle and loads the register defaults.
`default_nettype none

module touch_move_smoothing_fsm
    import tms_pkg::*;
#(
    parameter int TIME_BITS  = 32,
    parameter int ALPHA_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // pos_y[23:0], now_ms[55:24]
    input  wire logic [4:0]  s_tuser,   // func[1:0], touch_kind[4:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // event_y[23:0], mode_after[25:24], zero[31:26]
    output logic [2:0]       m_tuser,   // intercept[0], event_valid[1], event_kind[2]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    cfg_t    cfg_reg;
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t step_res;
    logic    accept;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.snap_thr    <= SNAP_THR_RST;
            cfg_reg.timeout_ms  <= TIMEOUT_MS_RST;
            cfg_reg.max_step_ms <= MAX_STEP_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SNAP_THR:    cfg_reg.snap_thr    <= cfg_wdata;
                CFG_TIMEOUT_MS:  cfg_reg.timeout_ms  <= cfg_wdata;
                CFG_MAX_STEP_MS: cfg_reg.max_step_ms <= cfg_wdata[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.func       <= s_tuser[1:0];
            in_item_reg.touch_kind <= s_tuser[4:2];
            in_item_reg.pos_y      <= s_tdata[23:0];
            in_item_reg.now_ms     <= s_tdata[55:24];
        end
        if (advance)
            out_res_reg <= step_res;
    end

    tms_engine #(
        .TIME_BITS  (TIME_BITS),
        .ALPHA_BITS (ALPHA_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.mode_after, out_res_reg.event_y};
    assign m_tuser  = {out_res_reg.event_kind, out_res_reg.event_valid, out_res_reg.intercept};

endmodule

`default_nettype wire

/* hdl/tms_check.sv */
// Port-level checks for the touch move smoothing block, bound to its top level.
`default_nettype none

module tms_check
    import tms_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // a held result must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an up kind only comes with a generated event
    a_kind_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1])
        else $error("event kind up without event");

    // every up event ends the gesture
    a_up_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tdata[25:24] == MODE_IDLE)
        else $error("up event without return to idle");

    // no event means a zero position and zero padding
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[23:0] == 24'd0 && m_tdata[31:26] == 6'd0)
        else $error("position set without event");

endmodule

bind touch_move_smoothing_fsm tms_check u_tms_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
